[rtl/nlc_pkg.sv]
`timescale 1ns / 1ps

package nlc_pkg;

	// Longest string that is counted; positions are measured within it.
	localparam int MAX_LEN = 4096;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	// Bit positions in the scan flag byte.
	localparam int F_SIGN    = 0;
	localparam int F_NEG     = 1;
	localparam int F_DOT     = 2;
	localparam int F_NUM     = 3;
	localparam int F_DOTNUM  = 4;
	localparam int F_EXP     = 5;
	localparam int F_EXPSIGN = 6;
	localparam int F_EXPNUM  = 7;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_L     = 8'h6C;

	typedef enum logic [2:0] {
		KIND_NULL = 3'd0,
		KIND_UINT = 3'd1,
		KIND_SINT = 3'd2,
		KIND_DEC  = 3'd3,
		KIND_STR  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0]       flags;
		logic [LEN_W-1:0] char_index;
		logic [LEN_W-1:0] dot_index;
		logic [LEN_W-1:0] exp_index;
		logic             is_text;
		logic [1:0]       null_track;
	} scan_state_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       flags;
		logic [LEN_W-1:0] dot_from_end;
		logic [LEN_W-1:0] exp_from_end;
	} scan_result_t;

	// Expected character of "null" at the first three places.
	function automatic logic [7:0] null_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = CH_N;
			2'd1:    c = CH_U;
			default: c = CH_L;
		endcase
		return c;
	endfunction

endpackage

[rtl/nlc_scan.sv]
`timescale 1ns / 1ps

module nlc_scan (
	input  nlc_pkg::scan_state_t  cur,
	input  logic [7:0]            ch,
	input  logic                  char_valid,
	input  logic                  last,
	output nlc_pkg::scan_state_t  nxt_state,
	output nlc_pkg::scan_result_t result
);
	import nlc_pkg::*;

	scan_state_t      nxt;
	logic             is_null;
	logic [LEN_W-1:0] idx;
	logic [7:0]       f;
	logic             text_end;

	assign idx = cur.char_index;
	assign f   = cur.flags;

	always_comb begin
		nxt     = cur;
		is_null = 1'b0;
		if (char_valid) begin
			if (idx >= LEN_W'(MAX_LEN)) begin
				nxt.is_text    = 1'b1;
				nxt.null_track = 2'd0;
			end else begin
				if (idx < LEN_W'(3) && cur.null_track == idx[1:0] &&
						ch == null_char(idx[1:0])) begin
					nxt.null_track = cur.null_track + 2'd1;
				end else if (!(idx == LEN_W'(3) && cur.null_track == 2'd3)) begin
					nxt.null_track = 2'd0;
				end

				if (!cur.is_text) begin
					if (ch == CH_MINUS || ch == CH_PLUS) begin
						// A sign may come once before any exponent, even after digits; an exponent takes one sign before its digits.
						if (f[F_EXPSIGN] || (!f[F_EXP] && f[F_SIGN]) || f[F_EXPNUM]) begin
							nxt.is_text = 1'b1;
						end else if (f[F_EXP]) begin
							nxt.flags[F_EXPSIGN] = 1'b1;
						end else begin
							nxt.flags[F_SIGN] = 1'b1;
							if (ch == CH_MINUS) begin
								nxt.flags[F_NEG] = 1'b1;
							end
						end
					end else if (ch == CH_DOT) begin
						if (f[F_EXP] || f[F_DOT]) begin
							nxt.is_text = 1'b1;
						end else begin
							nxt.flags[F_DOT] = 1'b1;
							nxt.dot_index    = idx;
						end
					end else if (ch == CH_LOW_E || ch == CH_UP_E) begin
						if (f[F_EXP]) begin
							nxt.is_text = 1'b1;
						end else begin
							nxt.flags[F_EXP] = 1'b1;
							nxt.exp_index    = idx;
						end
					end else if (ch >= CH_0 && ch <= CH_9) begin
						if (f[F_EXP]) begin
							nxt.flags[F_EXPNUM] = 1'b1;
						end else if (f[F_DOT]) begin
							nxt.flags[F_NUM]    = 1'b1;
							nxt.flags[F_DOTNUM] = 1'b1;
						end else begin
							nxt.flags[F_NUM] = 1'b1;
						end
					end else begin
						nxt.is_text = 1'b1;
					end
				end

				if (idx == LEN_W'(3) && nxt.null_track == 2'd3 && ch == CH_L && last) begin
					is_null = 1'b1;
				end else if (idx == LEN_W'(3)) begin
					nxt.null_track = 2'd0;
				end
				nxt.char_index = idx + LEN_W'(1);
			end
		end
	end

	// A number needs digits, and an exponent needs digits of its own.
	assign text_end = nxt.is_text || !nxt.flags[F_NUM] ||
		(nxt.flags[F_EXP] && !nxt.flags[F_EXPNUM]);

	always_comb begin
		result = '0;
		if (nxt.char_index == '0 || is_null) begin
			result.kind = KIND_NULL;
		end else begin
			result.flags = nxt.flags;
			if (text_end) begin
				result.kind = KIND_STR;
			end else if (nxt.flags[F_DOT] || nxt.flags[F_EXP]) begin
				result.kind = KIND_DEC;
			end else if (nxt.flags[F_NEG]) begin
				result.kind = KIND_SINT;
			end else begin
				result.kind = KIND_UINT;
			end
			if (nxt.flags[F_DOT]) begin
				result.dot_from_end = nxt.char_index - nxt.dot_index;
			end
			if (nxt.flags[F_EXP]) begin
				result.exp_from_end = nxt.char_index - nxt.exp_index;
			end
		end
	end

	// The string ends with the last item and the scanner starts over.
	assign nxt_state = last ? scan_state_t'('0) : nxt;

endmodule

[rtl/numeric_literal_classifier.sv]
`timescale 1ns / 1ps

// Numeric literal classifier. Characters of a value string arrive one per
// transaction on the input channel, the final one marked by last; a
// transaction with char_valid low carries no character, so a lone such
// transaction with last high is an empty string. For each string one result
// transaction comes out, after its last input, giving the kind (null, unsigned
// integer, signed integer, decimal or plain string), the eight scan flags and
// the positions of the dot and the exponent mark counted from the end of the
// string (zero when absent). A string of more than 4096 characters is plain
// text and its positions are measured from a length of 4096. The block takes
// one character every cycle: an input register feeds one pass of flag logic
// into the result register, and the input keeps flowing while a result waits
// for the consumer, except that a second finished result stalls the input
// until the first is taken. There are no configuration registers.
module numeric_literal_classifier (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                ch,
	input  logic                      char_valid,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                value_kind,
	output logic [7:0]                scan_flags,
	output logic [nlc_pkg::LEN_W-1:0] dot_from_end,
	output logic [nlc_pkg::LEN_W-1:0] exp_from_end
);
	import nlc_pkg::*;

	// Input register.
	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        char_valid_s1;
	logic        last_s1;

	// Scanner state and result register.
	scan_state_t  st_q;
	scan_state_t  st_next;
	scan_result_t res;
	logic         out_valid_q;
	scan_result_t res_q;

	logic adv;

	// A character that ends no string can always move on; a last one needs
	// the result register to be free or emptying.
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	nlc_scan u_scan (
		.cur        (st_q),
		.ch         (ch_s1),
		.char_valid (char_valid_s1),
		.last       (last_s1),
		.nxt_state  (st_next),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1         <= ch;
			char_valid_s1 <= char_valid;
			last_s1       <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign value_kind   = res_q.kind;
	assign scan_flags   = res_q.flags;
	assign dot_from_end = res_q.dot_from_end;
	assign exp_from_end = res_q.exp_from_end;

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q == scan_state_t'('0))
		else $error("scanner state not cleared after end of string");

	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result appeared without a string ending");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.char_index <= LEN_W'(MAX_LEN))
		else $error("character count beyond maximum length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(adv && last_s1))
		else $error("pending result overwritten");

	a_dot_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.flags[F_DOT] |-> res_q.dot_from_end == '0)
		else $error("dot position without dot flag");
`endif

endmodule
